/* design/ssw_pkg.sv */
// ----------------------------------------------------------------------------
// ssw_pkg: shared types and constants for the seven point stencil sweep
// Register indexes, item control flags and divide-by-ten constants.
// ----------------------------------------------------------------------------
package ssw_pkg;

  localparam int DATA_W    = 32;
  localparam int SIZE_X_W  = 11;
  localparam int SIZE_Y_W  = 7;
  localparam int SIZE_Z_W  = 7;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } cfg_reg_t;

  localparam logic MODE_DRAIN = 1'b1;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    logic res;
    logic last;
    logic ym_en;
    logic yp_en;
    logic zm_en;
    logic zp_en;
    logic xm_en;
    logic xp_en;
  } ssw_item_t;

  // Partial sums, full sum and magnitude widths.
  localparam int PA_W  = 35;
  localparam int PB_W  = 34;
  localparam int SUM_W = 36;
  localparam int MAG_W = 35;

  // floor(m / 10) == (m * RECIP_10) >> RECIP_SHIFT for every m below 2**38.
  localparam int              RECIP_W     = 36;
  localparam logic [RECIP_W-1:0] RECIP_10 = 36'd54975581389;
  localparam int              RECIP_SHIFT = 39;
  localparam int              MAG_SPLIT   = 18;

endpackage

/* design/ssw_store.sv */
// ----------------------------------------------------------------------------
// ssw_store: plane store bank
// One write port and two registered read ports, read-before-write.
// ----------------------------------------------------------------------------
module ssw_store import ssw_pkg::*; #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  word_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output word_t         rd_data_a,
  output word_t         rd_data_b
);

  word_t mem [DEPTH];
  word_t rd_a_r;
  word_t rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

/* design/ssw_ctrl.sv */
// ----------------------------------------------------------------------------
// ssw_ctrl: raster cursor and store addressing
// Tracks the voxel and drain cursors, builds the six read addresses, the
// write address and the per-item stencil flags.
// ----------------------------------------------------------------------------
module ssw_ctrl import ssw_pkg::*; #(
  parameter int MAX_X = 1024,
  parameter int MAX_Y = 64,
  parameter int MAX_Z = 64,
  parameter int AW    = 13
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                mode,
  input  logic [SIZE_X_W-1:0] size_x,
  input  logic [SIZE_Y_W-1:0] size_y,
  input  logic [SIZE_Z_W-1:0] size_z,
  output ssw_item_t           item,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [AW-1:0]       addr_c,
  output logic [AW-1:0]       addr_xm,
  output logic [AW-1:0]       addr_ym,
  output logic [AW-1:0]       addr_yp,
  output logic [AW-1:0]       addr_zm,
  output logic [AW-1:0]       addr_zp
);

  localparam int XW  = (MAX_X > 1) ? $clog2(MAX_X) : 1;
  localparam int YW  = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int ZW  = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
  localparam int XCW = $clog2(MAX_X + 1);
  localparam int YCW = $clog2(MAX_Y + 1);
  localparam int ZCW = $clog2(MAX_Z + 1);

  logic [XW-1:0]  pos_x_r, pos_x_nxt;
  logic [YW-1:0]  pos_y_r, pos_y_nxt;
  logic [ZW-1:0]  pos_z_r, pos_z_nxt;
  logic           pending_r, pending_nxt;

  logic [XCW-1:0] sx;
  logic [YCW-1:0] sy;
  logic [ZCW-1:0] sz;
  logic           voxel;
  logic           restart;
  logic [XW-1:0]  cx;
  logic [YW-1:0]  cy;
  logic [ZW-1:0]  cz;
  logic [XCW-1:0] x_inc;
  logic [YCW-1:0] y_inc;
  logic [ZCW-1:0] z_inc;
  logic           x_wrap;
  logic           y_wrap;
  logic           z_wrap;
  logic           par;

  function automatic logic [AW-1:0] slot(input logic p, input logic [YW-1:0] y,
                                         input logic [ZW-1:0] z);
    slot = AW'((AW'(p) * AW'(MAX_Y) + AW'(y)) * AW'(MAX_Z) + AW'(z));
  endfunction

  // clamp extents to [1, max]
  always_comb begin
    if (size_x == '0) begin
      sx = XCW'(1);
    end else if (32'(size_x) > MAX_X) begin
      sx = XCW'(MAX_X);
    end else begin
      sx = XCW'(size_x);
    end
    if (size_y == '0) begin
      sy = YCW'(1);
    end else if (32'(size_y) > MAX_Y) begin
      sy = YCW'(MAX_Y);
    end else begin
      sy = YCW'(size_y);
    end
    if (size_z == '0) begin
      sz = ZCW'(1);
    end else if (32'(size_z) > MAX_Z) begin
      sz = ZCW'(MAX_Z);
    end else begin
      sz = ZCW'(size_z);
    end
  end

  always_comb begin
    voxel   = (mode != MODE_DRAIN);
    restart = voxel && pending_r;
    cx      = restart ? '0 : pos_x_r;
    cy      = restart ? '0 : pos_y_r;
    cz      = restart ? '0 : pos_z_r;
    x_inc   = XCW'(cx) + XCW'(1);
    y_inc   = YCW'(cy) + YCW'(1);
    z_inc   = ZCW'(cz) + ZCW'(1);
    x_wrap  = (x_inc >= sx);
    y_wrap  = (y_inc >= sy);
    z_wrap  = (z_inc >= sz);
    par     = voxel ? ~cx[0] : ~sx[0];
  end

  always_comb begin
    item.res   = voxel ? (cx != '0) : pending_r;
    item.last  = !voxel && z_wrap && y_wrap;
    item.ym_en = (cy != '0);
    item.yp_en = (y_inc < sy);
    item.zm_en = (cz != '0);
    item.zp_en = (z_inc < sz);
    item.xm_en = voxel ? ((XCW + 1)'(cx) >= (XCW + 1)'(2))
                       : ((XCW + 1)'(sx) >= (XCW + 1)'(2));
    item.xp_en = voxel;

    addr_c  = slot(par, cy, cz);
    addr_xm = slot(~par, cy, cz);
    addr_ym = slot(par, cy - YW'(1), cz);
    addr_yp = slot(par, cy + YW'(1), cz);
    addr_zm = slot(par, cy, cz - ZW'(1));
    addr_zp = slot(par, cy, cz + ZW'(1));

    wr_en   = accept && voxel;
    wr_addr = addr_xm;
  end

  always_comb begin
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    pos_z_nxt   = pos_z_r;
    pending_nxt = pending_r;
    if (accept) begin
      if (voxel) begin
        pos_z_nxt = z_wrap ? '0 : ZW'(z_inc);
        pos_y_nxt = z_wrap ? (y_wrap ? '0 : YW'(y_inc)) : cy;
        pos_x_nxt = (z_wrap && y_wrap) ? (x_wrap ? '0 : XW'(x_inc)) : cx;
        pending_nxt = z_wrap && y_wrap && x_wrap;
      end else if (pending_r) begin
        // last drain lands on both wraps, leaving the cursor at the origin
        pos_z_nxt   = z_wrap ? '0 : ZW'(z_inc);
        pos_y_nxt   = z_wrap ? (y_wrap ? '0 : YW'(y_inc)) : cy;
        pending_nxt = !(z_wrap && y_wrap);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      pos_z_r   <= '0;
      pending_r <= 1'b0;
    end else begin
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
      pos_z_r   <= pos_z_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule

/* design/ssw_calc.sv */
// ----------------------------------------------------------------------------
// ssw_calc: stencil arithmetic pipeline
// Masks the neighbours, sums ten terms, divides by ten toward zero through a
// split reciprocal multiply, and holds the result register.
// ----------------------------------------------------------------------------
module ssw_calc import ssw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  ssw_item_t item,
  input  word_t     xp,
  input  word_t     c,
  input  word_t     xm,
  input  word_t     ym,
  input  word_t     yp,
  input  word_t     zm,
  input  word_t     zp,
  output logic      load_rdy,
  input  logic      out_stall,
  output logic      out_valid,
  output word_t     out_result,
  output logic      out_last
);

  localparam int PH_W   = MAG_W - MAG_SPLIT + RECIP_W;
  localparam int PL_W   = MAG_SPLIT + RECIP_W;
  localparam int PROD_W = MAG_W + RECIP_W;

  logic                    v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;
  logic                    rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy_o;
  ssw_item_t               it1_r;
  word_t                   xp1_r;
  logic                    last2_r, last3_r, last4_r, last5_r, last6_r, out_last_r;
  logic signed [PA_W-1:0]  pa2_r, pa_nxt;
  logic signed [PB_W-1:0]  pb2_r, pb_nxt;
  logic signed [SUM_W-1:0] sum3_r, sum_nxt;
  logic                    neg4_r, neg5_r, neg6_r, neg_nxt;
  logic [MAG_W-1:0]        mag4_r, mag_nxt;
  logic [PH_W-1:0]         ph5_r, ph_nxt;
  logic [PL_W-1:0]         pl5_r, pl_nxt;
  logic [PROD_W-1:0]       prod;
  logic [DATA_W-1:0]       q6_r, q_nxt;
  word_t                   out_result_r, result_nxt;
  word_t                   ym_m, yp_m, zm_m, zp_m, xm_m, xp_m;

  always_comb begin
    rdy_o    = !out_valid_r || !out_stall;
    rdy6     = !v6_r || rdy_o;
    rdy5     = !v5_r || rdy6;
    rdy4     = !v4_r || rdy5;
    rdy3     = !v3_r || rdy4;
    rdy2     = !v2_r || rdy3;
    rdy1     = !v1_r || rdy2;
    load_rdy = rdy1;
  end

  always_comb begin
    ym_m = it1_r.ym_en ? ym : '0;
    yp_m = it1_r.yp_en ? yp : '0;
    zm_m = it1_r.zm_en ? zm : '0;
    zp_m = it1_r.zp_en ? zp : '0;
    xm_m = it1_r.xm_en ? xm : '0;
    xp_m = it1_r.xp_en ? xp1_r : '0;
    pa_nxt  = (PA_W'(c) <<< 2) + PA_W'(ym_m) + PA_W'(yp_m);
    pb_nxt  = PB_W'(zm_m) + PB_W'(zp_m) + PB_W'(xm_m) + PB_W'(xp_m);
    sum_nxt = SUM_W'(pa2_r) + SUM_W'(pb2_r);
    neg_nxt = sum3_r[SUM_W-1];
    mag_nxt = neg_nxt ? MAG_W'(-sum3_r) : MAG_W'(sum3_r);
    ph_nxt  = PH_W'(mag4_r[MAG_W-1:MAG_SPLIT]) * PH_W'(RECIP_10);
    pl_nxt  = PL_W'(mag4_r[MAG_SPLIT-1:0]) * PL_W'(RECIP_10);
    prod    = (PROD_W'(ph5_r) << MAG_SPLIT) + PROD_W'(pl5_r);
    q_nxt   = DATA_W'(prod >> RECIP_SHIFT);
    result_nxt = neg6_r ? word_t'(-q6_r) : word_t'(q6_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= load && item.res;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
      if (rdy5) begin
        v5_r <= v4_r;
      end
      if (rdy6) begin
        v6_r <= v5_r;
      end
      if (rdy_o) begin
        out_valid_r <= v6_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      it1_r <= item;
      xp1_r <= xp;
    end
    if (rdy2 && v1_r) begin
      pa2_r   <= pa_nxt;
      pb2_r   <= pb_nxt;
      last2_r <= it1_r.last;
    end
    if (rdy3 && v2_r) begin
      sum3_r  <= sum_nxt;
      last3_r <= last2_r;
    end
    if (rdy4 && v3_r) begin
      mag4_r  <= mag_nxt;
      neg4_r  <= neg_nxt;
      last4_r <= last3_r;
    end
    if (rdy5 && v4_r) begin
      ph5_r   <= ph_nxt;
      pl5_r   <= pl_nxt;
      neg5_r  <= neg4_r;
      last5_r <= last4_r;
    end
    if (rdy6 && v5_r) begin
      q6_r    <= q_nxt;
      neg6_r  <= neg5_r;
      last6_r <= last5_r;
    end
    if (rdy_o && v6_r) begin
      out_result_r <= result_nxt;
      out_last_r   <= last6_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_last   = out_last_r;

endmodule

/* design/seven_point_stencil_sweep_top.sv */
// ----------------------------------------------------------------------------
// seven_point_stencil_sweep_top: one Jacobi sweep of a 7-point 3D stencil
//
//   channel  direction  handshake            payload
//   in       into       in_valid/in_stall    in_mode, in_value
//   out      out of     out_valid/out_stall  out_result, out_last
//   cfg      into       cfg_wr_en            cfg_index, cfg_data
//
// Sustains one input transfer per cycle while in_stall is low. A result
// passes the input, pa2, sum3, mag4, ph5, q6 and result registers. Three
// replicated store banks, each with two read ports, supply the six neighbour
// reads of an item in its accept cycle. Reset clears the cursors, the drain
// flag and the pipeline valids, not the plane store, which needs no clearing.
// out_stall backs up stage by stage; in_stall rises only with every stage full.
// ----------------------------------------------------------------------------
module seven_point_stencil_sweep_top import ssw_pkg::*; #(
  parameter int MAX_X = 1024,
  parameter int MAX_Y = 64,
  parameter int MAX_Z = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_mode,
  input  logic signed [31:0]   in_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_result,
  output logic                 out_last,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int DEPTH = 2 * MAX_Y * MAX_Z;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SIZE_X_W-1:0] size_x_r;
  logic [SIZE_Y_W-1:0] size_y_r;
  logic [SIZE_Z_W-1:0] size_z_r;
  logic                accept;
  logic                load_rdy;
  ssw_item_t           item;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       addr_c, addr_xm, addr_ym, addr_yp, addr_zm, addr_zp;
  word_t               rd_c, rd_xm, rd_ym, rd_yp, rd_zm, rd_zp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_X_W'(1);
      size_y_r <= SIZE_Y_W'(1);
      size_z_r <= SIZE_Z_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SIZE_X: size_x_r <= cfg_data[SIZE_X_W-1:0];
        REG_SIZE_Y: size_y_r <= cfg_data[SIZE_Y_W-1:0];
        REG_SIZE_Z: size_z_r <= cfg_data[SIZE_Z_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept   = in_valid && load_rdy;
  assign in_stall = !load_rdy;

  ssw_ctrl #(
    .MAX_X (MAX_X),
    .MAX_Y (MAX_Y),
    .MAX_Z (MAX_Z),
    .AW    (AW)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .mode    (in_mode),
    .size_x  (size_x_r),
    .size_y  (size_y_r),
    .size_z  (size_z_r),
    .item    (item),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .addr_c  (addr_c),
    .addr_xm (addr_xm),
    .addr_ym (addr_ym),
    .addr_yp (addr_yp),
    .addr_zm (addr_zm),
    .addr_zp (addr_zp)
  );

  ssw_store #(.DEPTH(DEPTH), .AW(AW)) u_store_cx (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (in_value),
    .rd_en     (accept),
    .rd_addr_a (addr_c),
    .rd_addr_b (addr_xm),
    .rd_data_a (rd_c),
    .rd_data_b (rd_xm)
  );

  ssw_store #(.DEPTH(DEPTH), .AW(AW)) u_store_y (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (in_value),
    .rd_en     (accept),
    .rd_addr_a (addr_ym),
    .rd_addr_b (addr_yp),
    .rd_data_a (rd_ym),
    .rd_data_b (rd_yp)
  );

  ssw_store #(.DEPTH(DEPTH), .AW(AW)) u_store_z (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (in_value),
    .rd_en     (accept),
    .rd_addr_a (addr_zm),
    .rd_addr_b (addr_zp),
    .rd_data_a (rd_zm),
    .rd_data_b (rd_zp)
  );

  ssw_calc u_calc (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .item       (item),
    .xp         (in_value),
    .c          (rd_c),
    .xm         (rd_xm),
    .ym         (rd_ym),
    .yp         (rd_yp),
    .zm         (rd_zm),
    .zp         (rd_zp),
    .load_rdy   (load_rdy),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_result (out_result),
    .out_last   (out_last)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the result register can drain");

  a_reset_empties_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule
